// File: design/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// shared constants, codes and types of the bilinear bayer demosaic unit
// ----------------------------------------------------------------------------
package bbd_pkg;

   // stream geometry and sample format
   localparam int MAX_WIDTH      = 2048;
   localparam int MAX_HEIGHT     = 4096;
   localparam int SAMPLE_BITS    = 16;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int EFF_WIDTH_BITS = $clog2(MAX_WIDTH + 1);
   // rows run up to the height plus two, where they park once the tail drains
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT + 3);
   localparam int SUM4_BITS      = SAMPLE_BITS + 2;
   localparam int SUM2_BITS      = SAMPLE_BITS + 1;

   // configuration register fields
   localparam int CFG_WIDTH_BITS  = 12;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int CFG_ORDER_BITS  = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_ORDER  = 0;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BAYER_ORDER  = 2'd2
   } csr_index_type;

   // color of the site: {row odd, column odd} after the order offsets
   typedef enum logic [1:0] {
      PHASE_RED     = 2'd0,
      PHASE_GREEN_R = 2'd1,
      PHASE_GREEN_B = 2'd2,
      PHASE_BLUE    = 2'd3
   } phase_type;

   // 3x3 neighborhood, row major, index 4 is the center
   typedef logic [8:0][SAMPLE_BITS-1:0] window_type;

   typedef struct packed {
      sample_type red;
      sample_type green;
      sample_type blue;
   } rgb_type;

   // line store ports
   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
   } lb_rd_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
      sample_type          data_a;
      sample_type          data_b;
   } lb_wr_type;

   typedef struct packed {
      sample_type a;
      sample_type b;
   } lb_data_type;

   // item in the memory read stage
   typedef struct packed {
      logic                is_pixel;
      logic                emit;
      logic                fill;
      logic                zero_col;
      logic                row_ge2;
      logic                eol;
      logic                eof;
      phase_type           phase;
      logic                fwd;
      logic [COL_BITS-1:0] addr;
      sample_type          sample;
   } stage_type;

endpackage

// File: design/bbd_stream_if.sv
// ----------------------------------------------------------------------------
// bbd_stream_if
// valid/ready channels of the demosaic unit: mosaic requests and rgb responses
// ----------------------------------------------------------------------------
interface bbd_req_if;
   logic                 valid;
   logic                 ready;
   bbd_pkg::opcode_type  opcode;
   bbd_pkg::sample_type  sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface bbd_rsp_if;
   logic                 valid;
   logic                 ready;
   bbd_pkg::sample_type  red;
   bbd_pkg::sample_type  green;
   bbd_pkg::sample_type  blue;
   logic                 end_of_line;
   logic                 end_of_frame;

   modport source (output valid, output red, output green, output blue,
                   output end_of_line, output end_of_frame, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input end_of_line, input end_of_frame, output ready);
endinterface

// File: design/bbd_line_buf.sv
// ----------------------------------------------------------------------------
// bbd_line_buf
// two line stores sharing one address: the previous row and the row before it
// ----------------------------------------------------------------------------
module bbd_line_buf (
   input  logic                 clock,
   input  bbd_pkg::lb_rd_type   rd,
   input  bbd_pkg::lb_wr_type   wr,
   output bbd_pkg::lb_data_type rd_data
);

   bbd_pkg::sample_type store_a_mem [bbd_pkg::MAX_WIDTH];
   bbd_pkg::sample_type store_b_mem [bbd_pkg::MAX_WIDTH];
   bbd_pkg::sample_type rd_a_ff;
   bbd_pkg::sample_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_a_mem[wr.addr] <= wr.data_a;
         store_b_mem[wr.addr] <= wr.data_b;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff <= store_a_mem[rd.addr];
         rd_b_ff <= store_b_mem[rd.addr];
      end
   end

   assign rd_data.a = rd_a_ff;
   assign rd_data.b = rd_b_ff;

endmodule

// File: design/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// bilinear interpolation of one 3x3 neighborhood into an rgb pixel
// ----------------------------------------------------------------------------
module bbd_interp (
   input  bbd_pkg::window_type win,
   input  bbd_pkg::phase_type  phase,
   output bbd_pkg::rgb_type    rgb
);

   logic [bbd_pkg::SUM4_BITS-1:0] edge_sum;
   logic [bbd_pkg::SUM4_BITS-1:0] diag_sum;
   logic [bbd_pkg::SUM2_BITS-1:0] horiz_sum;
   logic [bbd_pkg::SUM2_BITS-1:0] vert_sum;
   bbd_pkg::sample_type           edge_avg;
   bbd_pkg::sample_type           diag_avg;
   bbd_pkg::sample_type           horiz_avg;
   bbd_pkg::sample_type           vert_avg;

   // averages round half up
   always_comb begin
      edge_sum  = bbd_pkg::SUM4_BITS'(win[1]) + bbd_pkg::SUM4_BITS'(win[7])
                + bbd_pkg::SUM4_BITS'(win[3]) + bbd_pkg::SUM4_BITS'(win[5])
                + bbd_pkg::SUM4_BITS'(2);
      diag_sum  = bbd_pkg::SUM4_BITS'(win[0]) + bbd_pkg::SUM4_BITS'(win[2])
                + bbd_pkg::SUM4_BITS'(win[6]) + bbd_pkg::SUM4_BITS'(win[8])
                + bbd_pkg::SUM4_BITS'(2);
      horiz_sum = bbd_pkg::SUM2_BITS'(win[3]) + bbd_pkg::SUM2_BITS'(win[5])
                + bbd_pkg::SUM2_BITS'(1);
      vert_sum  = bbd_pkg::SUM2_BITS'(win[1]) + bbd_pkg::SUM2_BITS'(win[7])
                + bbd_pkg::SUM2_BITS'(1);
      edge_avg  = edge_sum[bbd_pkg::SUM4_BITS-1:2];
      diag_avg  = diag_sum[bbd_pkg::SUM4_BITS-1:2];
      horiz_avg = horiz_sum[bbd_pkg::SUM2_BITS-1:1];
      vert_avg  = vert_sum[bbd_pkg::SUM2_BITS-1:1];
   end

   always_comb begin
      unique case (phase)
         bbd_pkg::PHASE_RED: begin
            rgb.red   = win[4];
            rgb.green = edge_avg;
            rgb.blue  = diag_avg;
         end
         bbd_pkg::PHASE_BLUE: begin
            rgb.red   = diag_avg;
            rgb.green = edge_avg;
            rgb.blue  = win[4];
         end
         bbd_pkg::PHASE_GREEN_R: begin
            rgb.red   = horiz_avg;
            rgb.green = win[4];
            rgb.blue  = vert_avg;
         end
         default: begin
            rgb.red   = vert_avg;
            rgb.green = win[4];
            rgb.blue  = horiz_avg;
         end
      endcase
   end

endmodule

// File: design/bayer_bilinear_demosaic_unit.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit
// Streaming 3x3 bilinear demosaic of a raster-order Bayer mosaic. Send one
// sample per transfer on req_ch; the full rgb pixel of raster position q comes
// out on rsp_ch when the sample of position q+W+1 goes in, and after the last
// sample of a frame W+1 flush transfers drain the remaining pixels (flushes at
// any other time are taken and ignored). Borders replicate the nearest pixel.
// The unit takes one transfer every cycle unless the input stalls: an item is
// accepted and reads both line stores at its column, is held with the read
// data in the read stage, then loads its result into the output register,
// from which it transfers on rsp_ch. The line stores are two 2048 x 16
// memories with one read and one write per cycle, so the column address
// sequence, not any loop, sets the rate. The input stalls only when the output
// register is full and not taken while the read stage also holds an item. The
// line stores need no clearing after reset. A write to a defined csr index
// restarts the stream at row 0, column 0; write only while the unit is idle.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit (
   input  logic                               clock,
   input  logic                               reset,
   bbd_req_if.sink                            req_ch,
   bbd_rsp_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [bbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bbd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration, stored already clamped
   logic [bbd_pkg::EFF_WIDTH_BITS-1:0] width_ff, width_in;
   logic [bbd_pkg::ROW_BITS-1:0]       height_ff, height_in;
   logic [bbd_pkg::CFG_ORDER_BITS-1:0] order_ff, order_in;
   logic [bbd_pkg::CFG_WIDTH_BITS-1:0]  width_field;
   logic [bbd_pkg::CFG_HEIGHT_BITS-1:0] height_field;
   logic                               csr_hit;

   // stream position of the next item
   logic [bbd_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [bbd_pkg::ROW_BITS-1:0] row_ff, row_in;

   // read stage and output register
   logic                 s1_valid_ff, s1_valid_in;
   bbd_pkg::stage_type   s1_ff, s1_in;
   logic                 out_valid_ff, out_valid_in;
   bbd_pkg::rgb_type     out_rgb_ff;
   logic                 out_eol_ff;
   logic                 out_eof_ff;

   // window and last line store write, for same-column forwarding
   bbd_pkg::window_type  window_ff, window_in;
   bbd_pkg::sample_type  last_a_ff;
   bbd_pkg::sample_type  last_b_ff;

   // handshake
   logic out_open;
   logic s1_fire;
   logic accept;

   // accept-side decode
   logic                             is_pixel;
   logic                             restart;
   logic                             proc;
   logic [bbd_pkg::COL_BITS-1:0]     col0;
   logic [bbd_pkg::ROW_BITS-1:0]     row0;
   logic [bbd_pkg::ROW_BITS-1:0]     height_p1;
   logic [bbd_pkg::ROW_BITS-1:0]     height_p2;
   logic [bbd_pkg::EFF_WIDTH_BITS-1:0] col_next;
   logic                             tail0;
   logic                             ox_odd;
   logic                             oy_odd;

   // read-stage datapath
   bbd_pkg::lb_rd_type   lb_rd;
   bbd_pkg::lb_wr_type   lb_wr;
   bbd_pkg::lb_data_type lb_data;
   bbd_pkg::sample_type  a_val, b_val;
   bbd_pkg::sample_type  col_top, col_mid, col_bot;
   bbd_pkg::sample_type  new_top, new_mid, new_bot;
   bbd_pkg::window_type  shifted;
   bbd_pkg::rgb_type     pix_rgb;

   // ---------------------------------------------------------------- config
   assign width_field  = csr_wdata[bbd_pkg::CFG_WIDTH_BITS-1:0];
   assign height_field = csr_wdata[bbd_pkg::CFG_HEIGHT_BITS-1:0];
   assign csr_hit = csr_wr_en && (csr_index == bbd_pkg::CSR_FRAME_WIDTH
                                  || csr_index == bbd_pkg::CSR_FRAME_HEIGHT
                                  || csr_index == bbd_pkg::CSR_BAYER_ORDER);

   // clamp width to 1..max and height to 1..max on the write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      order_in  = order_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH: begin
               if (width_field == '0) begin
                  width_in = bbd_pkg::EFF_WIDTH_BITS'(1);
               end else if (32'(width_field) > 32'(bbd_pkg::MAX_WIDTH)) begin
                  width_in = bbd_pkg::EFF_WIDTH_BITS'(bbd_pkg::MAX_WIDTH);
               end else begin
                  width_in = bbd_pkg::EFF_WIDTH_BITS'(width_field);
               end
            end
            bbd_pkg::CSR_FRAME_HEIGHT: begin
               if (height_field == '0) begin
                  height_in = bbd_pkg::ROW_BITS'(1);
               end else if (32'(height_field) > 32'(bbd_pkg::MAX_HEIGHT)) begin
                  height_in = bbd_pkg::ROW_BITS'(bbd_pkg::MAX_HEIGHT);
               end else begin
                  height_in = bbd_pkg::ROW_BITS'(height_field);
               end
            end
            bbd_pkg::CSR_BAYER_ORDER: begin
               order_in = csr_wdata[bbd_pkg::CFG_ORDER_BITS-1:0];
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bbd_pkg::EFF_WIDTH_BITS'(bbd_pkg::RESET_WIDTH);
         height_ff <= bbd_pkg::ROW_BITS'(bbd_pkg::RESET_HEIGHT);
         order_ff  <= bbd_pkg::CFG_ORDER_BITS'(bbd_pkg::RESET_ORDER);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         order_ff  <= order_in;
      end
   end

   // ------------------------------------------------------------- handshake
   // output register frees up when empty or taken; the read stage moves on then
   assign out_open     = !out_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && out_open;
   assign req_ch.ready = !s1_valid_ff || out_open;
   assign accept       = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------- accept stage
   assign is_pixel  = (req_ch.opcode == bbd_pkg::OP_PIXEL);
   assign height_p1 = height_ff + bbd_pkg::ROW_BITS'(1);
   assign height_p2 = height_ff + bbd_pkg::ROW_BITS'(2);

   // a pixel after the frame is done opens a new frame at the origin
   assign restart = is_pixel && (row_ff >= height_ff);
   assign col0    = restart ? '0 : col_ff;
   assign row0    = restart ? '0 : row_ff;
   assign tail0   = (row0 == height_p1);

   // flushes count only on the bottom border row and the final tail column
   assign proc = is_pixel || (row_ff == height_ff) || (row_ff == height_p1);

   assign col_next = bbd_pkg::EFF_WIDTH_BITS'(col0) + bbd_pkg::EFF_WIDTH_BITS'(1);

   always_comb begin
      col_in = col0;
      row_in = row0;
      if (tail0) begin
         // frame fully drained, park past the tail
         row_in = height_p2;
      end else if (col_next >= width_ff) begin
         col_in = '0;
         row_in = row0 + bbd_pkg::ROW_BITS'(1);
      end else begin
         col_in = col_next[bbd_pkg::COL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept && proc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // output coordinates: column 0 closes the row two back, else the pixel
   // left of this column one row back
   assign ox_odd = (col0 == '0) ? ~width_ff[0] : ~col0[0];
   assign oy_odd = (col0 == '0) ? row0[0] : ~row0[0];

   always_comb begin
      s1_in.is_pixel = is_pixel;
      s1_in.zero_col = (col0 == '0);
      s1_in.row_ge2  = (row0 >= bbd_pkg::ROW_BITS'(2));
      s1_in.emit     = s1_in.zero_col ? s1_in.row_ge2 : (row0 != '0);
      s1_in.fill     = s1_in.zero_col && (row0 <= height_ff);
      s1_in.eol      = s1_in.zero_col;
      s1_in.eof      = s1_in.zero_col && tail0;
      s1_in.phase    = bbd_pkg::phase_type'({oy_odd ^ order_ff[1], ox_odd ^ order_ff[0]});
      // the read here misses a write to the same column landing this edge
      s1_in.fwd      = s1_fire && s1_ff.is_pixel && (s1_ff.addr == col0);
      s1_in.addr     = col0;
      s1_in.sample   = req_ch.sample;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = proc;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------------------ line stores
   assign lb_rd.en   = accept;
   assign lb_rd.addr = col0;

   assign lb_wr.en     = s1_fire && s1_ff.is_pixel;
   assign lb_wr.addr   = s1_ff.addr;
   assign lb_wr.data_a = s1_ff.sample;
   assign lb_wr.data_b = a_val;

   bbd_line_buf u_line_buf (
      .clock   (clock),
      .rd      (lb_rd),
      .wr      (lb_wr),
      .rd_data (lb_data)
   );

   always_ff @(posedge clock) begin
      if (lb_wr.en) begin
         last_a_ff <= lb_wr.data_a;
         last_b_ff <= lb_wr.data_b;
      end
   end

   // ------------------------------------------------------------- read stage
   assign a_val = s1_ff.fwd ? last_a_ff : lb_data.a;
   assign b_val = s1_ff.fwd ? last_b_ff : lb_data.b;

   // top row replicates on the first rows, bottom on flushes
   assign col_mid = a_val;
   assign col_top = s1_ff.row_ge2 ? b_val : a_val;
   assign col_bot = s1_ff.is_pixel ? s1_ff.sample : a_val;

   // column 0 closes the previous row by replicating its right column
   assign new_top = s1_ff.zero_col ? window_ff[2] : col_top;
   assign new_mid = s1_ff.zero_col ? window_ff[5] : col_mid;
   assign new_bot = s1_ff.zero_col ? window_ff[8] : col_bot;

   always_comb begin
      shifted[0] = window_ff[1];
      shifted[1] = window_ff[2];
      shifted[2] = new_top;
      shifted[3] = window_ff[4];
      shifted[4] = window_ff[5];
      shifted[5] = new_mid;
      shifted[6] = window_ff[7];
      shifted[7] = window_ff[8];
      shifted[8] = new_bot;
   end

   // a new row starts with its first column replicated across the window
   always_comb begin
      if (s1_ff.fill) begin
         window_in = {col_bot, col_bot, col_bot,
                      col_mid, col_mid, col_mid,
                      col_top, col_top, col_top};
      end else begin
         window_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         window_ff <= window_in;
      end
   end

   bbd_interp u_interp (
      .win   (shifted),
      .phase (s1_ff.phase),
      .rgb   (pix_rgb)
   );

   // -------------------------------------------------------- output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_open) begin
         out_valid_in = s1_valid_ff && s1_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.emit) begin
         out_rgb_ff <= pix_rgb;
         out_eol_ff <= s1_ff.eol;
         out_eof_ff <= s1_ff.eof;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.red          = out_rgb_ff.red;
   assign rsp_ch.green        = out_rgb_ff.green;
   assign rsp_ch.blue         = out_rgb_ff.blue;
   assign rsp_ch.end_of_line  = out_eol_ff;
   assign rsp_ch.end_of_frame = out_eof_ff;

endmodule

// File: design/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// port-level checks of the demosaic unit, bound to the top level
// ----------------------------------------------------------------------------
module bbd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bbd_pkg::sample_type rsp_red,
   input bbd_pkg::sample_type rsp_green,
   input bbd_pkg::sample_type rsp_blue,
   input logic                rsp_end_of_line,
   input logic                rsp_end_of_frame
);

   // a stalled result stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue)
         && $stable(rsp_end_of_line) && $stable(rsp_end_of_frame))
      else $error("rsp transfer changed while stalled");

   // the last pixel of a frame is also the last of its row
   a_eof_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_line)
      else $error("end_of_frame without end_of_line");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an empty output register never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_bbd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_red          (rsp_ch.red),
   .rsp_green        (rsp_ch.green),
   .rsp_blue         (rsp_ch.blue),
   .rsp_end_of_line  (rsp_ch.end_of_line),
   .rsp_end_of_frame (rsp_ch.end_of_frame)
);
